/* src/assert_macros.svh */
// Assertion macros shared by the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SACK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SACK_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SACK_ASSERT(lbl, prop, msg)
`define SACK_NEVER(lbl, cond, msg)
`endif
`endif

/* src/sack_pkg.sv */
// Package with the types and constants of the selective ack tracker.
package sack_pkg;
  localparam int MAX_CHUNKS = 4096;
  localparam int WIN_BITS   = 64;
  localparam int NUM_WIN    = MAX_CHUNKS / WIN_BITS;
  localparam int WIN_AW     = $clog2(NUM_WIN);
  localparam int CNT_W      = 13;
  localparam int OUT_W      = 152;

  localparam logic [2:0] CFG_NUM_CHUNKS  = 3'd0;
  localparam logic [2:0] CFG_ACK_BATCH   = 3'd1;
  localparam logic [2:0] CFG_ACK_TIMEOUT = 3'd2;
  localparam logic [2:0] CFG_MSG_ID      = 3'd3;
  localparam logic [2:0] CFG_FLOW_ID     = 3'd4;

  typedef logic [WIN_BITS-1:0] word_t;
  typedef logic [WIN_AW-1:0]   waddr_t;

  typedef struct packed {
    logic   we;
    waddr_t addr;
    word_t  data;
  } bm_wr_t;
endpackage

/* src/sack_bitmap.sv */
// Received-chunk bitmap memory with per-row valid bits cleared at reset.
module sack_bitmap import sack_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  bm_wr_t wr,
  input  waddr_t raddr,
  output word_t  rdata
);
  word_t              mem [NUM_WIN];
  logic [NUM_WIN-1:0] row_vld_r;
  word_t              rd_r;
  logic               rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      rd_vld_r <= row_vld_r[raddr];
      if (wr.we) begin
        row_vld_r[wr.addr] <= 1'b1;
      end
    end
  end

  // A row never written since reset reads as all zero.
  assign rdata = rd_vld_r ? rd_r : '0;
endmodule

/* src/chunk_receipt_sack_tracker.sv */
// Top level of the selective ack tracker: sequencer, counters and ack output.
// A tick is taken in idle, or starts a flush. A chunk passes through update and
// decision; a new chunk adds a cumulative scan that steps over each chunk passed,
// stops, and reloads each word crossed, fetching the pointer's word first if the chunk
// is not the one it awaits. A flush runs order read, bitmap read, load and handoff (held
// while out_tready is low) per dirty window, then closes. rst_n is synchronous.
`include "assert_macros.svh"
module chunk_receipt_sack_tracker import sack_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [15:0]      in_tdata,   // [15:0] chunk_index
  input  logic             in_tuser,   // [0] req_type
  output logic             out_tvalid,
  input  logic             out_tready,
  // [15:0] ack_flow, [47:16] ack_msg, [59:48] win_base, [123:60] window_bitmap,
  // [136:124] cumulative_ack, [149:137] high_ack, [150] done_res, [151] zero
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_UPD, S_SRD, S_SCAN, S_SCLD, S_DEC, S_FORD, S_FWRD, S_FOUT, S_FWAIT
  } st_t;

  // Configuration registers.
  logic [CNT_W-1:0] num_r;
  logic [15:0]      batch_r;
  logic [31:0]      timeout_r;
  logic [31:0]      msg_r;
  logic [15:0]      flow_r;

  st_t st_r, st_nxt;
  logic [11:0]        chunk_r, chunk_nxt;
  word_t              cache_r, cache_nxt;
  logic [CNT_W-1:0]   contig_r, contig_nxt, high_r, high_nxt, rcv_r, rcv_nxt;
  logic [15:0]        since_r, since_nxt;
  logic [31:0]        ticks_r, ticks_nxt;
  logic [NUM_WIN-1:0] dirty_r, dirty_nxt;
  logic [WIN_AW:0]    dcnt_r, dcnt_nxt, k_r, k_nxt;
  logic               fdone_r, fdone_nxt;
  waddr_t             win_r, win_nxt;
  logic               ov_r, ov_nxt, olast_r, olast_nxt;
  logic [OUT_W-1:0]   od_r, od_nxt;

  // Dirty-window order store; entries are used only below the dirty count.
  waddr_t order_mem [NUM_WIN];
  waddr_t order_q_r;
  logic   ord_we;

  bm_wr_t           bm_wr;
  waddr_t           bm_raddr;
  word_t            bm_rdata;
  logic [CNT_W-1:0] n_eff;
  word_t            wnew, wmask;
  logic [CNT_W-1:0] base_ext, diff;
  logic [31:0]      ticks_inc;

  sack_bitmap u_bitmap (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (bm_wr),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  assign n_eff      = (num_r > CNT_W'(MAX_CHUNKS)) ? CNT_W'(MAX_CHUNKS) : num_r;
  assign in_tready  = (st_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = olast_r;
  assign wnew       = bm_rdata | (word_t'(1) << chunk_r[5:0]);
  assign ticks_inc  = (ticks_r == 32'hFFFF_FFFF) ? ticks_r : ticks_r + 32'd1;
  assign base_ext   = {1'b0, win_r, 6'b0};
  assign diff       = n_eff - base_ext;

  // Bitmap of a window is clipped to chunks below the current chunk count.
  always_comb begin
    if (base_ext >= n_eff) begin
      wmask = '0;
    end else if (diff < CNT_W'(WIN_BITS)) begin
      wmask = (word_t'(1) << diff[5:0]) - word_t'(1);
    end else begin
      wmask = '1;
    end
  end

  always_comb begin
    st_nxt     = st_r;
    chunk_nxt  = chunk_r;
    cache_nxt  = cache_r;
    contig_nxt = contig_r;
    high_nxt   = high_r;
    rcv_nxt    = rcv_r;
    since_nxt  = since_r;
    ticks_nxt  = ticks_r;
    dirty_nxt  = dirty_r;
    dcnt_nxt   = dcnt_r;
    k_nxt      = k_r;
    fdone_nxt  = fdone_r;
    win_nxt    = win_r;
    ov_nxt     = ov_r;
    olast_nxt  = olast_r;
    od_nxt     = od_r;
    bm_wr      = '0;
    bm_raddr   = chunk_r[11:6];
    ord_we     = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser) begin
            ticks_nxt = ticks_inc;
            if (since_r != 16'd0 && ticks_inc >= timeout_r) begin
              fdone_nxt = 1'b0;
              k_nxt     = '0;
              st_nxt    = S_FORD;
            end
          end else if (in_tdata < {3'b0, n_eff}) begin
            chunk_nxt = in_tdata[11:0];
            bm_raddr  = in_tdata[11:6];
            st_nxt    = S_UPD;
          end
        end
      end
      S_UPD: begin
        cache_nxt = wnew;
        if (!bm_rdata[chunk_r[5:0]]) begin
          bm_wr = '{we: 1'b1, addr: chunk_r[11:6], data: wnew};
          rcv_nxt = rcv_r + 1'b1;
          if ({1'b0, chunk_r} + 1'b1 > high_r) begin
            high_nxt = {1'b0, chunk_r} + 1'b1;
          end
        end
        if (since_r != 16'hFFFF) begin
          since_nxt = since_r + 16'd1;
        end
        if (!dirty_r[chunk_r[11:6]] && dcnt_r < (WIN_AW+1)'(NUM_WIN)) begin
          dirty_nxt[chunk_r[11:6]] = 1'b1;
          ord_we   = 1'b1;
          dcnt_nxt = dcnt_r + 1'b1;
        end
        // Every new chunk rescans from the pointer while it is below the chunk count, since a
        // raised chunk count can expose received chunks that lay beyond the old end.
        if (!bm_rdata[chunk_r[5:0]] && {1'b0, chunk_r} == contig_r) begin
          st_nxt = S_SCAN;
        end else if (!bm_rdata[chunk_r[5:0]] && contig_r < n_eff) begin
          st_nxt = S_SRD;
        end else begin
          st_nxt = S_DEC;
        end
      end
      S_SRD: begin
        // The word under the pointer is read after this chunk's write has landed.
        bm_raddr = contig_r[11:6];
        st_nxt   = S_SCLD;
      end
      S_SCAN: begin
        if (contig_r < n_eff && cache_r[contig_r[5:0]]) begin
          contig_nxt = contig_r + 1'b1;
          if (contig_r[5:0] == 6'h3F) begin
            bm_raddr = contig_nxt[11:6];
            st_nxt   = S_SCLD;
          end
        end else begin
          st_nxt = S_DEC;
        end
      end
      S_SCLD: begin
        cache_nxt = bm_rdata;
        st_nxt    = S_SCAN;
      end
      S_DEC: begin
        fdone_nxt = (rcv_r == n_eff);
        k_nxt     = '0;
        if (rcv_r == n_eff || chunk_r[5:0] == 6'h3F ||
            {1'b0, chunk_r} + 1'b1 == n_eff || since_r >= batch_r) begin
          st_nxt = S_FORD;
        end else begin
          st_nxt = S_IDLE;
        end
      end
      S_FORD: begin
        if (k_r == dcnt_r) begin
          dcnt_nxt  = '0;
          k_nxt     = '0;
          since_nxt = '0;
          ticks_nxt = '0;
          st_nxt    = S_IDLE;
        end else begin
          st_nxt = S_FWRD;
        end
      end
      S_FWRD: begin
        win_nxt  = order_q_r;
        bm_raddr = order_q_r;
        st_nxt   = S_FOUT;
      end
      S_FOUT: begin
        od_nxt = {1'b0, fdone_r, high_r, contig_r, bm_rdata & wmask,
                  win_r, 6'b0, msg_r, flow_r};
        olast_nxt = (k_r + 1'b1 == dcnt_r);
        ov_nxt    = 1'b1;
        dirty_nxt[win_r] = 1'b0;
        st_nxt    = S_FWAIT;
      end
      S_FWAIT: begin
        if (out_tready) begin
          ov_nxt = 1'b0;
          k_nxt  = k_r + 1'b1;
          st_nxt = S_FORD;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      order_mem[dcnt_r[WIN_AW-1:0]] <= chunk_r[11:6];
    end
    order_q_r <= order_mem[k_r[WIN_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      contig_r  <= '0;
      high_r    <= '0;
      rcv_r     <= '0;
      since_r   <= '0;
      ticks_r   <= '0;
      dirty_r   <= '0;
      dcnt_r    <= '0;
      k_r       <= '0;
      ov_r      <= 1'b0;
      num_r     <= CNT_W'(256);
      batch_r   <= 16'd64;
      timeout_r <= 32'd1000;
      msg_r     <= '0;
      flow_r    <= '0;
    end else begin
      st_r     <= st_nxt;
      contig_r <= contig_nxt;
      high_r   <= high_nxt;
      rcv_r    <= rcv_nxt;
      since_r  <= since_nxt;
      ticks_r  <= ticks_nxt;
      dirty_r  <= dirty_nxt;
      dcnt_r   <= dcnt_nxt;
      k_r      <= k_nxt;
      ov_r     <= ov_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_NUM_CHUNKS:  num_r     <= cfg_data[CNT_W-1:0];
          CFG_ACK_BATCH:   batch_r   <= cfg_data[15:0];
          CFG_ACK_TIMEOUT: timeout_r <= cfg_data;
          CFG_MSG_ID:      msg_r     <= cfg_data;
          CFG_FLOW_ID:     flow_r    <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    chunk_r <= chunk_nxt;
    cache_r <= cache_nxt;
    fdone_r <= fdone_nxt;
    win_r   <= win_nxt;
    olast_r <= olast_nxt;
    od_r    <= od_nxt;
  end

  `SACK_ASSERT(a_ov_state, ov_r |-> st_r == S_FWAIT, "ack valid outside handoff state")
  `SACK_NEVER(a_busy_out, in_tready && out_tvalid, "input taken while an ack waits")
  `SACK_ASSERT(a_contig_le_high, contig_r <= high_r, "cumulative ack beyond highest")
  `SACK_ASSERT(a_dcnt_max, dcnt_r <= (WIN_AW+1)'(NUM_WIN), "dirty count overflow")
  `SACK_ASSERT(a_k_le_dcnt, k_r <= dcnt_r, "flush index beyond dirty count")
endmodule
